// ----- rtl/tmw_pkg.sv -----
// Shared constants and types for the text-mode terminal writer.
// No dependencies; imported by every module of the block.
`default_nettype none

package tmw_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  localparam int REQ_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int RROW_W  = 5;
  localparam int RCOL_W  = 7;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 8;

  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
  localparam logic [CELL_W-1:0]  RESET_CELL  = 16'h0720;

  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT    = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

endpackage

`default_nettype wire

// ----- rtl/tmw_cell_ram.sv -----
// Screen cell store: one write port, one read port, registered read data.
// Depends on tmw_pkg for the cell width.
`default_nettype none

module tmw_cell_ram #(
  parameter int DEPTH = tmw_pkg::COLUMNS_DEF * tmw_pkg::ROWS_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ADDR_W-1:0]           waddr,
  input  wire logic [tmw_pkg::CELL_W-1:0]  wdata,
  input  wire logic                        re,
  input  wire logic [ADDR_W-1:0]           raddr,
  output logic      [tmw_pkg::CELL_W-1:0]  rdata
);
  import tmw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tmw_ctrl.sv -----
// Sequencer for the terminal writer: cursor, row rotation, clear and blank sweeps.
// Depends on tmw_pkg; drives the ports of tmw_cell_ram.
`default_nettype none

module tmw_ctrl #(
  parameter int COLUMNS  = tmw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tmw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tmw_pkg::TAB_STOP_DEF,
  localparam int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [tmw_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [tmw_pkg::CHAR_W-1:0]   in_char_code,
  input  wire logic [tmw_pkg::RROW_W-1:0]   in_read_row,
  input  wire logic [tmw_pkg::RCOL_W-1:0]   in_read_col,
  input  wire logic                         cfg_we,
  input  wire logic [tmw_pkg::COLOR_W-1:0]  cfg_wdata,
  output logic                              out_valid,
  output logic      [tmw_pkg::POS_W-1:0]    out_cursor_pos,
  output logic      [tmw_pkg::CELL_W-1:0]   out_cell_data,
  output logic                              out_scrolled,
  output logic                              mem_we,
  output logic      [ADDR_W-1:0]            mem_waddr,
  output logic      [tmw_pkg::CELL_W-1:0]   mem_wdata,
  output logic                              mem_re,
  output logic      [ADDR_W-1:0]            mem_raddr,
  input  wire logic [tmw_pkg::CELL_W-1:0]   mem_rdata
);
  import tmw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int TAB_W  = $clog2(TAB_STOP);
  localparam int TCOL_W = COL_W + TAB_W;
  localparam int LIN_W  = $clog2(CELLS);
  localparam logic [TAB_W-1:0] LAST_MOD = TAB_W'((COLUMNS - 1) % TAB_STOP);
  localparam logic [TAB_W-1:0] TAB_MAX  = TAB_W'(TAB_STOP - 1);
  localparam logic [COL_W-1:0] COL_MAX  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX  = ROW_W'(ROWS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_BLANK = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [TAB_W-1:0]   mod_r, mod_nxt;
  logic [ROW_W-1:0]   base_r, base_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic [ADDR_W-1:0]  blank_addr_r, blank_addr_nxt;
  logic [COL_W-1:0]   cnt_r, cnt_nxt;
  logic               scroll_r, scroll_nxt;
  logic               hit_r, hit_nxt;
  logic [COLOR_W-1:0] color_r;

  req_t               req_r;
  logic [CHAR_W-1:0]  ch_r;
  logic [RROW_W-1:0]  rrow_r;
  logic [RCOL_W-1:0]  rcol_r;

  logic               out_valid_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [CELL_W-1:0]  out_cell_r;
  logic               out_scr_r;

  logic               nl;
  logic [TCOL_W-1:0]  tab_col;
  logic [LIN_W-1:0]   lin;

  // logical row to physical row under the scroll rotation
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] b);
    logic [ROW_W:0] s;
    s = {1'b0, r} + {1'b0, b};
    if (int'(s) >= ROWS) begin
      s = s - (ROW_W + 1)'(ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * COLUMNS + int'(c));
  endfunction

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_data  = out_cell_r;
  assign out_scrolled   = out_scr_r;
  assign lin            = LIN_W'(int'(row_r) * COLUMNS + int'(col_r));

  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    mod_nxt        = mod_r;
    base_nxt       = base_r;
    clr_nxt        = clr_r;
    blank_addr_nxt = blank_addr_r;
    cnt_nxt        = cnt_r;
    scroll_nxt     = scroll_r;
    hit_nxt        = hit_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    nl             = 1'b0;
    tab_col        = TCOL_W'(col_r) + TCOL_W'(TAB_STOP) - TCOL_W'(mod_r);

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = RESET_CELL;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt  = ST_EXEC;
          scroll_nxt = 1'b0;
          hit_nxt    = 1'b0;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
        case (req_r)
          REQ_PUT: begin
            if (ch_r == CH_RETURN) begin
              col_nxt = '0;
              mod_nxt = '0;
            end else if (ch_r == CH_NEWLINE) begin
              nl = 1'b1;
            end else if (ch_r == CH_TAB) begin
              if (int'(tab_col) >= COLUMNS) begin
                nl = 1'b1;
              end else begin
                col_nxt = tab_col[COL_W-1:0];
                mod_nxt = '0;
              end
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr(phys_row(row_r, base_r), col_r);
              mem_wdata = {color_r, ch_r};
              if (col_r == COL_MAX) begin
                nl = 1'b1;
              end else begin
                col_nxt = col_r + 1'b1;
                mod_nxt = (mod_r == TAB_MAX) ? '0 : mod_r + 1'b1;
              end
            end
          end
          REQ_DELETE: begin
            if (col_r != '0) begin
              col_nxt   = col_r - 1'b1;
              mod_nxt   = (mod_r == '0) ? TAB_MAX : mod_r - 1'b1;
              mem_we    = 1'b1;
              mem_waddr = cell_addr(phys_row(row_r, base_r), col_r - 1'b1);
              mem_wdata = {color_r, CH_SPACE};
            end else if (row_r != '0) begin
              row_nxt   = row_r - 1'b1;
              col_nxt   = COL_MAX;
              mod_nxt   = LAST_MOD;
              mem_we    = 1'b1;
              mem_waddr = cell_addr(phys_row(row_r - 1'b1, base_r), COL_MAX);
              mem_wdata = {color_r, CH_SPACE};
            end
          end
          REQ_READ: begin
            if (int'(rrow_r) < ROWS && int'(rcol_r) < COLUMNS) begin
              mem_re    = 1'b1;
              mem_raddr = cell_addr(phys_row(ROW_W'(rrow_r), base_r), COL_W'(rcol_r));
              hit_nxt   = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (nl) begin
          col_nxt = '0;
          mod_nxt = '0;
          if (row_r == ROW_MAX) begin
            // rotate: old top row becomes the bottom row, then blank it
            scroll_nxt     = 1'b1;
            base_nxt       = (base_r == ROW_MAX) ? '0 : base_r + 1'b1;
            blank_addr_nxt = cell_addr(base_r, '0);
            cnt_nxt        = '0;
            state_nxt      = ST_BLANK;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      ST_BLANK: begin
        mem_we         = 1'b1;
        mem_waddr      = blank_addr_r;
        mem_wdata      = {color_r, CH_SPACE};
        blank_addr_nxt = blank_addr_r + 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == COL_MAX) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      col_r       <= '0;
      row_r       <= '0;
      mod_r       <= '0;
      base_r      <= '0;
      clr_r       <= '0;
      scroll_r    <= 1'b0;
      hit_r       <= 1'b0;
      color_r     <= RESET_COLOR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      mod_r       <= mod_nxt;
      base_r      <= base_nxt;
      clr_r       <= clr_nxt;
      scroll_r    <= scroll_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= (state_r == ST_RESP);
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    blank_addr_r <= blank_addr_nxt;
    cnt_r        <= cnt_nxt;
    if (state_r == ST_IDLE && start) begin
      req_r  <= req_t'(in_req_type);
      ch_r   <= in_char_code;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
    end
    if (state_r == ST_RESP) begin
      out_pos_r  <= POS_W'(lin);
      out_cell_r <= hit_r ? mem_rdata : '0;
      out_scr_r  <= scroll_r;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/text_mode_terminal_writer_top.sv -----
// Top level of the text-mode terminal writer: sequencer plus screen cell store.
// Depends on tmw_pkg, tmw_cell_ram and tmw_ctrl.
//
//   channel  ports                                          handshake
//   input    in_req_type in_char_code in_read_row in_read_col  start & !busy
//   result   out_cursor_pos out_cell_data out_scrolled     out_valid, one cycle
//   config   cfg_wdata                                      cfg_we
//
// An accepted item passes the exec and response states; out_valid is high in
// the cycle after the response state, when start may already be taken again.
// On a scroll the write port blanks the new bottom row before the response state.
// After reset a sweep writes blanks to all ROWS*COLUMNS cells, one per cycle,
// with busy high; cfg_we is taken throughout.
// Results are never held off by the receiver.
`default_nettype none

module text_mode_terminal_writer_top #(
  parameter int COLUMNS  = tmw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tmw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tmw_pkg::TAB_STOP_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [tmw_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [tmw_pkg::CHAR_W-1:0]   in_char_code,
  input  wire logic [tmw_pkg::RROW_W-1:0]   in_read_row,
  input  wire logic [tmw_pkg::RCOL_W-1:0]   in_read_col,
  input  wire logic                         cfg_we,
  input  wire logic [tmw_pkg::COLOR_W-1:0]  cfg_wdata,
  output logic                              out_valid,
  output logic      [tmw_pkg::POS_W-1:0]    out_cursor_pos,
  output logic      [tmw_pkg::CELL_W-1:0]   out_cell_data,
  output logic                              out_scrolled
);
  import tmw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  tmw_ctrl #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_data  (out_cell_data),
    .out_scrolled   (out_scrolled),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  tmw_cell_ram #(
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
